@@ src/kss_pkg.sv @@
// Package: shared types and codes for the keyed stack and queue store.
`timescale 1ns / 1ps
package kss_pkg;

    localparam int OP_W     = 3;
    localparam int STAT_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int LOC_W    = 2;
    localparam int SIZE_W   = 7;

    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd2;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd3;
    localparam logic [OP_W-1:0] OP_S2Q     = 3'd4;
    localparam logic [OP_W-1:0] OP_Q2S     = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUP   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MISS  = 3'd4;

    localparam logic [LOC_W-1:0] LOC_NONE  = 2'd0;
    localparam logic [LOC_W-1:0] LOC_STACK = 2'd1;
    localparam logic [LOC_W-1:0] LOC_QUEUE = 2'd2;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_STACK_RD,
        RES_QUEUE_RD,
        RES_HIT
    } res_sel_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] key;
        logic [DATA_W-1:0]        price;
    } kss_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] out_key;
        logic [DATA_W-1:0]        out_price;
        logic [POS_W-1:0]         position;
        logic [LOC_W-1:0]         location;
        logic [SIZE_W-1:0]        stack_size;
        logic [SIZE_W-1:0]        queue_size;
    } kss_out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic [DATA_W-1:0]        price;
    } kss_entry_t;

    typedef struct packed {
        logic              load_in;
        logic              scan_start;
        logic              scan_step;
        logic              rd_stack;
        logic              rd_queue;
        logic              stack_push;
        logic              stack_pop;
        logic              queue_push;
        logic              queue_pop;
        logic              from_read;
        logic              load_out;
        logic [STAT_W-1:0] status;
        res_sel_t          res_sel;
    } kss_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            stack_empty;
        logic            stack_full;
        logic            queue_empty;
        logic            queue_full;
        logic            scan_done;
        logic            hit;
    } kss_stat_t;

endpackage

@@ src/kss_ctrl.sv @@
// Controller: sequences decode, key scan, memory read, commit and result transfer.
`timescale 1ns / 1ps
module kss_ctrl
    import kss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  kss_stat_t stat,
    output kss_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DECIDE,
        SCAN,
        READ,
        COMMIT,
        FINISH
    } state_t;

    typedef struct packed {
        logic stack_push;
        logic stack_pop;
        logic queue_push;
        logic queue_pop;
        logic from_read;
    } act_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;
    res_sel_t          sel_reg, sel_next;
    act_t              act_reg, act_next;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        sel_next     = sel_reg;
        act_next     = act_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.status   = status_reg;
        cmd.res_sel  = sel_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = DECIDE;
                end
            end
            DECIDE: begin
                status_next = STAT_OK;
                sel_next    = RES_NONE;
                act_next    = '0;
                state_next  = FINISH;
                unique case (stat.op)
                    OP_PUSH: begin
                        if (stat.stack_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            act_next.stack_push = 1'b1;
                            cmd.scan_start      = 1'b1;
                            state_next          = SCAN;
                        end
                    end
                    OP_ENQUEUE: begin
                        if (stat.queue_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            act_next.queue_push = 1'b1;
                            cmd.scan_start      = 1'b1;
                            state_next          = SCAN;
                        end
                    end
                    OP_POP: begin
                        if (stat.stack_empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            act_next.stack_pop = 1'b1;
                            sel_next           = RES_STACK_RD;
                            state_next         = READ;
                        end
                    end
                    OP_DEQUEUE: begin
                        if (stat.queue_empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            act_next.queue_pop = 1'b1;
                            sel_next           = RES_QUEUE_RD;
                            state_next         = READ;
                        end
                    end
                    OP_S2Q: begin
                        if (stat.stack_empty) begin
                            status_next = STAT_EMPTY;
                        end else if (stat.queue_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            act_next   = '{stack_push: 1'b0, stack_pop: 1'b1,
                                           queue_push: 1'b1, queue_pop: 1'b0,
                                           from_read: 1'b1};
                            sel_next   = RES_STACK_RD;
                            state_next = READ;
                        end
                    end
                    OP_Q2S: begin
                        if (stat.queue_empty) begin
                            status_next = STAT_EMPTY;
                        end else if (stat.stack_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            act_next   = '{stack_push: 1'b1, stack_pop: 1'b0,
                                           queue_push: 1'b0, queue_pop: 1'b1,
                                           from_read: 1'b1};
                            sel_next   = RES_QUEUE_RD;
                            state_next = READ;
                        end
                    end
                    OP_SEARCH: begin
                        cmd.scan_start = 1'b1;
                        state_next     = SCAN;
                    end
                    default: begin
                        state_next = FINISH;
                    end
                endcase
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = FINISH;
                    if (stat.op == OP_SEARCH) begin
                        if (stat.hit) begin
                            sel_next = RES_HIT;
                        end else begin
                            status_next = STAT_MISS;
                        end
                    end else if (stat.hit) begin
                        status_next = STAT_DUP;
                    end else begin
                        state_next = COMMIT;
                    end
                end
            end
            READ: begin
                cmd.rd_stack = act_reg.stack_pop;
                cmd.rd_queue = act_reg.queue_pop;
                state_next   = COMMIT;
            end
            COMMIT: begin
                cmd.stack_push = act_reg.stack_push;
                cmd.stack_pop  = act_reg.stack_pop;
                cmd.queue_push = act_reg.queue_push;
                cmd.queue_pop  = act_reg.queue_pop;
                cmd.from_read  = act_reg.from_read;
                state_next     = FINISH;
            end
            FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            status_reg  <= STAT_OK;
            sel_reg     <= RES_NONE;
            act_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            sel_reg     <= sel_next;
            act_reg     <= act_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ src/kss_dp.sv @@
// Datapath: stack and queue memories, pointers, key scan and result register.
`timescale 1ns / 1ps
module kss_dp
    import kss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  kss_in_t   in_data,
    input  kss_cmd_t  cmd,
    output kss_stat_t stat,
    output kss_out_t  out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    kss_entry_t stack_mem [DEPTH];
    kss_entry_t queue_mem [DEPTH];

    kss_in_t    in_reg;
    kss_out_t   out_reg;
    kss_entry_t stack_rd_reg, queue_rd_reg;

    logic [CW-1:0] sc_reg, sc_next;
    logic [CW-1:0] qc_reg, qc_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;

    logic [CW-1:0] idx_reg;
    logic [AW-1:0] qptr_reg;
    logic [CW-1:0] p_idx_reg;
    logic          p_s_vld_reg, p_q_vld_reg;
    logic          s_hit_reg, q_hit_reg;
    logic [CW-1:0] s_pos_reg, q_pos_reg;
    logic [DATA_W-1:0] s_price_reg, q_price_reg;

    logic [CW-1:0] limit;
    logic [CW-1:0] sc_dec;
    logic          issue, issue_s, issue_q;
    logic          stack_re, queue_re, stack_we, queue_we;
    logic [AW-1:0] stack_raddr, queue_raddr;
    kss_entry_t    in_entry, stack_wdata, queue_wdata;
    kss_out_t      out_next;

    assign in_entry    = '{key: in_reg.key, price: in_reg.price};
    assign limit       = (sc_reg > qc_reg) ? sc_reg : qc_reg;
    assign sc_dec      = sc_reg - CW'(1);
    assign issue       = cmd.scan_step && (idx_reg < limit);
    assign issue_s     = issue && (idx_reg < sc_reg);
    assign issue_q     = issue && (idx_reg < qc_reg);
    assign stack_re    = issue_s || cmd.rd_stack;
    assign queue_re    = issue_q || cmd.rd_queue;
    assign stack_raddr = cmd.rd_stack ? sc_dec[AW-1:0] : idx_reg[AW-1:0];
    assign queue_raddr = cmd.rd_queue ? head_reg : qptr_reg;
    assign stack_we    = cmd.stack_push;
    assign queue_we    = cmd.queue_push;
    assign stack_wdata = cmd.from_read ? queue_rd_reg : in_entry;
    assign queue_wdata = cmd.from_read ? stack_rd_reg : in_entry;

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[sc_reg[AW-1:0]] <= stack_wdata;
        end
        if (stack_re) begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (queue_we) begin
            queue_mem[tail_reg] <= queue_wdata;
        end
        if (queue_re) begin
            queue_rd_reg <= queue_mem[queue_raddr];
        end
    end

    always_comb begin
        sc_next   = sc_reg;
        qc_next   = qc_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.stack_push) begin
            sc_next = sc_reg + CW'(1);
        end else if (cmd.stack_pop) begin
            sc_next = sc_dec;
        end
        if (cmd.queue_push) begin
            qc_next   = qc_reg + CW'(1);
            tail_next = wrap_inc(tail_reg);
        end else if (cmd.queue_pop) begin
            qc_next   = qc_reg - CW'(1);
            head_next = wrap_inc(head_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg      <= '0;
            qc_reg      <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            idx_reg     <= '0;
            qptr_reg    <= '0;
            p_s_vld_reg <= 1'b0;
            p_q_vld_reg <= 1'b0;
            s_hit_reg   <= 1'b0;
            q_hit_reg   <= 1'b0;
        end else begin
            sc_reg   <= sc_next;
            qc_reg   <= qc_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cmd.scan_start) begin
                idx_reg     <= '0;
                qptr_reg    <= head_reg;
                p_s_vld_reg <= 1'b0;
                p_q_vld_reg <= 1'b0;
                s_hit_reg   <= 1'b0;
                q_hit_reg   <= 1'b0;
            end else begin
                p_s_vld_reg <= issue_s;
                p_q_vld_reg <= issue_q;
                if (issue) begin
                    idx_reg  <= idx_reg + CW'(1);
                    qptr_reg <= wrap_inc(qptr_reg);
                end
                if (p_s_vld_reg && !s_hit_reg && stack_rd_reg.key == in_reg.key) begin
                    s_hit_reg <= 1'b1;
                end
                if (p_q_vld_reg && !q_hit_reg && queue_rd_reg.key == in_reg.key) begin
                    q_hit_reg <= 1'b1;
                end
            end
        end
    end

    // first-hit payload, captured alongside the hit flags
    always_ff @(posedge aclk) begin
        p_idx_reg <= idx_reg;
        if (p_s_vld_reg && !s_hit_reg && stack_rd_reg.key == in_reg.key) begin
            s_pos_reg   <= p_idx_reg;
            s_price_reg <= stack_rd_reg.price;
        end
        if (p_q_vld_reg && !q_hit_reg && queue_rd_reg.key == in_reg.key) begin
            q_pos_reg   <= p_idx_reg;
            q_price_reg <= queue_rd_reg.price;
        end
        if (cmd.load_in) begin
            in_reg <= in_data;
        end
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        out_next            = '0;
        out_next.status     = cmd.status;
        out_next.stack_size = SIZE_W'(sc_reg);
        out_next.queue_size = SIZE_W'(qc_reg);
        case (cmd.res_sel)
            RES_STACK_RD: begin
                out_next.out_key   = stack_rd_reg.key;
                out_next.out_price = stack_rd_reg.price;
            end
            RES_QUEUE_RD: begin
                out_next.out_key   = queue_rd_reg.key;
                out_next.out_price = queue_rd_reg.price;
            end
            RES_HIT: begin
                out_next.out_key = in_reg.key;
                if (s_hit_reg) begin
                    out_next.out_price = s_price_reg;
                    out_next.position  = POS_W'(s_pos_reg);
                    out_next.location  = LOC_STACK;
                end else begin
                    out_next.out_price = q_price_reg;
                    out_next.position  = POS_W'(q_pos_reg);
                    out_next.location  = LOC_QUEUE;
                end
            end
            default: begin
                out_next.location = LOC_NONE;
            end
        endcase
    end

    assign stat.op          = in_reg.op;
    assign stat.stack_empty = (sc_reg == '0);
    assign stat.stack_full  = (sc_reg == CW'(DEPTH));
    assign stat.queue_empty = (qc_reg == '0);
    assign stat.queue_full  = (qc_reg == CW'(DEPTH));
    assign stat.scan_done   = (idx_reg >= limit) && !p_s_vld_reg && !p_q_vld_reg;
    assign stat.hit         = s_hit_reg || q_hit_reg;
    assign out_data         = out_reg;

endmodule

@@ src/keyed_stack_and_queue_store.sv @@
// Top level: keyed stack and queue store, controller plus datapath.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   kss_in_t  (op, key, price)
//  m_       out        m_valid / m_ready   kss_out_t (status .. queue_size)
//
// One transfer in, one transfer out. Insert and search scan stack and queue in
// parallel, one entry of each per cycle, then insert commits; search and duplicate
// refusal go straight to the result. Pop, dequeue and moves do one memory read
// and one commit; refusals and the unused code go straight to the result.
// Reset is synchronous on aresetn and empties both stores, no clearing pass.
// A held result does not block the next input transfer; completion waits on m_ready.
`timescale 1ns / 1ps
module keyed_stack_and_queue_store
    import kss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  kss_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output kss_out_t m_data
);

    kss_cmd_t  cmd;
    kss_stat_t stat;

    kss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

endmodule
